### hdl/pps_pkg.sv
package pps_pkg;

	// Default sizing of the task table
	localparam int MAX_TASKS_DEF = 16;
	localparam int PRIO_BITS_DEF = 8;

	// Widths of the transfer fields
	localparam int CMD_W     = 2;
	localparam int SLOT_IN_W = 4;
	localparam int ARR_W     = 16;
	localparam int BURST_W   = 16;
	localparam int PRIO_IN_W = 8;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Control from the sequencer to the selection unit
	typedef struct packed {
		logic              init;
		logic              sample;
		logic [TIME_W-1:0] now;
	} sel_ctrl_t;

endpackage

### hdl/pps_if.sv
// Command channel: one load, tick or clear per transfer.
interface pps_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [pps_pkg::CMD_W-1:0]          command;
	logic [pps_pkg::SLOT_IN_W-1:0]      task_slot;
	logic [pps_pkg::ARR_W-1:0]          arrival_time;
	logic [pps_pkg::BURST_W-1:0]        burst_length;
	logic [pps_pkg::PRIO_IN_W-1:0]      task_priority;

	modport source (output valid, command, task_slot, arrival_time, burst_length,
		task_priority, input ready);
	modport sink (input valid, command, task_slot, arrival_time, burst_length,
		task_priority, output ready);
endinterface

// Result channel: one transfer per tick.
interface pps_res_if;
	logic                               valid;
	logic                               ready;
	logic                               idle;
	logic [pps_pkg::SLOT_IN_W-1:0]      running_slot;
	logic                               task_finished;
	logic [pps_pkg::TIME_W-1:0]         finish_time;
	logic                               all_done;

	modport source (output valid, idle, running_slot, task_finished, finish_time,
		all_done, input ready);
	modport sink (input valid, idle, running_slot, task_finished, finish_time,
		all_done, output ready);
endinterface

### hdl/preemptive_priority_scheduler.sv
// Channel | Role | Transfer carries
// cmd     | sink   | command, task_slot, arrival_time, burst_length, task_priority
// res     | source | idle, running_slot, task_finished, finish_time, all_done
//
// A load reads the old slot on accept, then writes it in the load state; a clear
// completes on accept. A tick reads the task memory once per slot, slot 0 on
// accept and the rest in the scan state, then passes a drain state for the last
// read and an update state that writes the winner back.
// No clearing pass follows reset: per-slot valid bits make the table read as empty.
// A result waits in an output register; a later load or clear proceeds meanwhile,
// and the next tick holds in its update cycle until the register is free.
module preemptive_priority_scheduler #(
	parameter int MAX_TASKS     = pps_pkg::MAX_TASKS_DEF,
	parameter int PRIORITY_BITS = pps_pkg::PRIO_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pps_cmd_if.sink        cmd,
	pps_res_if.source      res
);

	localparam int SLOT_W  = $clog2(MAX_TASKS);
	localparam int ENTRY_W = pps_pkg::ARR_W + pps_pkg::BURST_W + PRIORITY_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;

	logic [2:0]                      state_q;
	logic                            cmd_acc;
	logic                            slot_ok;
	logic [SLOT_W-1:0]               slot_q;
	logic [pps_pkg::ARR_W-1:0]       arr_q;
	logic [pps_pkg::BURST_W-1:0]     burst_q;
	logic [PRIORITY_BITS-1:0]        prio_q;
	logic [SLOT_W-1:0]               idx_q;
	logic                            smp_s1;
	logic [SLOT_W-1:0]               slot_s1;
	logic                            rd_vld_s1;
	logic [MAX_TASKS-1:0]            valid_q;
	logic [pps_pkg::TIME_W-1:0]      time_q;
	logic [pps_pkg::COUNT_W-1:0]     cnt_q;

	logic                            re;
	logic [SLOT_W-1:0]               raddr;
	logic                            we;
	logic [SLOT_W-1:0]               waddr;
	logic [ENTRY_W-1:0]              wdata;
	logic [ENTRY_W-1:0]              rdata;
	logic [ENTRY_W-1:0]              entry;
	logic [pps_pkg::ARR_W-1:0]       rd_arr;
	logic [pps_pkg::BURST_W-1:0]     rd_rem;
	logic [PRIORITY_BITS-1:0]        rd_prio;

	pps_pkg::sel_ctrl_t              sel_ctrl;
	logic                            found;
	logic [SLOT_W-1:0]               best_slot;
	logic [pps_pkg::ARR_W-1:0]       best_arr;
	logic [pps_pkg::BURST_W-1:0]     best_rem;
	logic [PRIORITY_BITS-1:0]        best_prio;

	logic                            upd_go;
	logic                            finished;
	logic [pps_pkg::TIME_W-1:0]      time_next;
	logic [pps_pkg::COUNT_W-1:0]     cnt_tick;
	logic [pps_pkg::COUNT_W-1:0]     cnt_load;

	logic                            res_valid_q;
	logic                            res_idle_q;
	logic [pps_pkg::SLOT_IN_W-1:0]   res_slot_q;
	logic                            res_fin_q;
	logic [pps_pkg::TIME_W-1:0]      res_time_q;
	logic                            res_done_q;

	// Input handshake: one command at a time.
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign slot_ok   = (32'(cmd.task_slot) < 32'(MAX_TASKS));

	// Task memory ports.
	assign re    = (cmd_acc && (cmd.command == pps_pkg::CMD_LOAD) && slot_ok) ||
		(cmd_acc && (cmd.command == pps_pkg::CMD_TICK)) || (state_q == ST_SCAN);
	assign raddr = (state_q != ST_IDLE) ? idx_q :
		(cmd.command == pps_pkg::CMD_TICK) ? '0 : SLOT_W'(cmd.task_slot);

	assign upd_go = (state_q == ST_UPDATE) && (!res_valid_q || res.ready);

	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = {arr_q, burst_q, prio_q};
		if (state_q == ST_LOAD) begin
			we = 1'b1;
		end else if (upd_go && found) begin
			we    = 1'b1;
			waddr = best_slot;
			wdata = {best_arr, best_rem - 16'd1, best_prio};
		end
	end

	pps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_TASKS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A slot never written since the last clear reads as empty.
	assign entry   = rd_vld_s1 ? rdata : '0;
	assign rd_arr  = entry[ENTRY_W-1 -: pps_pkg::ARR_W];
	assign rd_rem  = entry[PRIORITY_BITS +: pps_pkg::BURST_W];
	assign rd_prio = entry[PRIORITY_BITS-1:0];

	assign sel_ctrl.init   = cmd_acc && (cmd.command == pps_pkg::CMD_TICK);
	assign sel_ctrl.sample = smp_s1;
	assign sel_ctrl.now    = time_q;

	pps_select #(
		.MAX_TASKS     (MAX_TASKS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sel_ctrl),
		.slot      (slot_s1),
		.arr       (rd_arr),
		.rem       (rd_rem),
		.prio      (rd_prio),
		.found     (found),
		.best_slot (best_slot),
		.best_arr  (best_arr),
		.best_rem  (best_rem),
		.best_prio (best_prio)
	);

	// Bookkeeping for the tick update and for a load.
	assign finished  = found && (best_rem == 16'd1);
	assign time_next = (time_q == '1) ? time_q : time_q + 32'd1;
	assign cnt_tick  = (finished && (cnt_q != '0)) ? cnt_q - 5'd1 : cnt_q;

	always_comb begin
		cnt_load = cnt_q;
		if ((rd_rem == '0) && (burst_q != '0)) begin
			if (cnt_q < pps_pkg::COUNT_MAX) begin
				cnt_load = cnt_q + 5'd1;
			end
		end else if ((rd_rem != '0) && (burst_q == '0)) begin
			if (cnt_q != '0) begin
				cnt_load = cnt_q - 5'd1;
			end
		end
	end

	// Sequencer and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			smp_s1    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			time_q    <= '0;
			cnt_q     <= '0;
		end else begin
			smp_s1 <= (state_q == ST_SCAN) || sel_ctrl.init;
			if (re) begin
				rd_vld_s1 <= valid_q[raddr];
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						case (cmd.command)
							pps_pkg::CMD_LOAD: begin
								if (slot_ok) begin
									state_q <= ST_LOAD;
								end
							end
							pps_pkg::CMD_TICK: begin
								idx_q   <= SLOT_W'(1);
								state_q <= ST_SCAN;
							end
							pps_pkg::CMD_CLEAR: begin
								valid_q <= '0;
								time_q  <= '0;
								cnt_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD: begin
					valid_q[slot_q] <= 1'b1;
					cnt_q           <= cnt_load;
					state_q         <= ST_IDLE;
				end
				ST_SCAN: begin
					if (idx_q == SLOT_W'(MAX_TASKS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_go) begin
						time_q  <= time_next;
						cnt_q   <= cnt_tick;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot 0 is read in the accept cycle, so the scan counter starts at one;
	// the first sample in the scan state belongs to slot 0.
	always_ff @(posedge clk) begin
		if (re) begin
			slot_s1 <= raddr;
		end
		if (cmd_acc) begin
			slot_q  <= SLOT_W'(cmd.task_slot);
			arr_q   <= cmd.arrival_time;
			burst_q <= cmd.burst_length;
			prio_q  <= PRIORITY_BITS'(cmd.task_priority);
		end
	end

	// Output register for the tick result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (upd_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			res_idle_q <= !found;
			res_slot_q <= found ? pps_pkg::SLOT_IN_W'(best_slot) : '0;
			res_fin_q  <= finished;
			res_time_q <= time_next;
			res_done_q <= (cnt_tick == '0);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.idle          = res_idle_q;
	assign res.running_slot  = res_slot_q;
	assign res.task_finished = res_fin_q;
	assign res.finish_time   = res_time_q;
	assign res.all_done      = res_done_q;

endmodule

### hdl/pps_ram.sv
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/pps_select.sv
module pps_select #(
	parameter int MAX_TASKS     = pps_pkg::MAX_TASKS_DEF,
	parameter int PRIORITY_BITS = pps_pkg::PRIO_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pps_pkg::sel_ctrl_t           ctrl,
	input  logic [$clog2(MAX_TASKS)-1:0] slot,
	input  logic [pps_pkg::ARR_W-1:0]    arr,
	input  logic [pps_pkg::BURST_W-1:0]  rem,
	input  logic [PRIORITY_BITS-1:0]     prio,
	output logic                         found,
	output logic [$clog2(MAX_TASKS)-1:0] best_slot,
	output logic [pps_pkg::ARR_W-1:0]    best_arr,
	output logic [pps_pkg::BURST_W-1:0]  best_rem,
	output logic [PRIORITY_BITS-1:0]     best_prio
);

	localparam int SLOT_W = $clog2(MAX_TASKS);

	logic                        found_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [pps_pkg::ARR_W-1:0]   arr_q;
	logic [pps_pkg::BURST_W-1:0] rem_q;
	logic [PRIORITY_BITS-1:0]    prio_q;
	logic                        ready_task;
	logic                        better;

	// A task competes once it has arrived and still has work. Equal priority
	// goes to the later arrival, and slots arrive in ascending order, so an
	// equal arrival hands the win to the higher slot.
	assign ready_task = (rem != '0) &&
		({{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, arr} <= ctrl.now);
	assign better = !found_q || (prio > prio_q) || ((prio == prio_q) && (arr >= arr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.init) begin
			found_q <= 1'b0;
		end else if (ctrl.sample && ready_task && better) begin
			found_q <= 1'b1;
		end
	end

	// Best candidate so far.
	always_ff @(posedge clk) begin
		if (ctrl.sample && ready_task && better) begin
			slot_q <= slot;
			arr_q  <= arr;
			rem_q  <= rem;
			prio_q <= prio;
		end
	end

	assign found     = found_q;
	assign best_slot = slot_q;
	assign best_arr  = arr_q;
	assign best_rem  = rem_q;
	assign best_prio = prio_q;

endmodule

### hdl/pps_chk.sv
module pps_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_ready,
	input logic [pps_pkg::CMD_W-1:0]       command,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic                            idle,
	input logic [pps_pkg::SLOT_IN_W-1:0]   running_slot,
	input logic                            task_finished,
	input logic [pps_pkg::TIME_W-1:0]      finish_time
);

	// A waiting result stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn before transfer");

	// An idle tick serves no slot and finishes nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && idle |-> (running_slot == '0) && !task_finished)
		else $error("idle result carries a slot or a finish");

	// Loads and clears never raise a result of their own.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (command != pps_pkg::CMD_TICK) && !res_valid
		|=> !res_valid)
		else $error("result raised by a load or clear");

	// A tick occupies the block for its scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (command == pps_pkg::CMD_TICK) |=> !cmd_ready)
		else $error("command accepted during a tick scan");

	// A completion always lies after time zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && task_finished |-> (finish_time != '0))
		else $error("task finished at time zero");

endmodule

bind preemptive_priority_scheduler pps_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.command       (cmd.command),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.idle          (res.idle),
	.running_slot  (res.running_slot),
	.task_finished (res.task_finished),
	.finish_time   (res.finish_time)
);
